// ----- rtl/nhe_pkg.sv -----
// ----------------------------------------------------------------------------
// nhe_pkg
// Shared types, character constants and helper functions of the name hex
// escape codec.
// ----------------------------------------------------------------------------
package nhe_pkg;

	localparam int MaxOut = 4;
	localparam int CntW   = $clog2(MaxOut + 1);

	localparam logic [7:0] SlashChar  = 8'h2F;
	localparam logic [7:0] HashChar   = 8'h23;
	localparam logic [3:0] NibbleMask = 4'hF;

	// Uppercase hex digits, indexed by nibble value.
	localparam logic [7:0] HexUpper [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	typedef struct packed {
		logic       at_start;
		logic [1:0] pend;
		logic [7:0] held;
	} nhe_state_t;

	localparam nhe_state_t StateReset = '{at_start: 1'b1, pend: 2'd0, held: 8'h00};

	typedef struct packed {
		logic [MaxOut-1:0][7:0] data;
		logic [CntW-1:0]        count;
		logic                   last;
	} nhe_result_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} nhe_digit_t;

	function automatic logic is_safe(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
		       (c >= 8'h30 && c <= 8'h39) || c == 8'h5F || c == 8'h2D || c == 8'h2E;
	endfunction

	function automatic nhe_digit_t hex_digit(input logic [7:0] c);
		nhe_digit_t d;
		d = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d.valid = 1'b1;
			d.value = c[3:0];
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			// Letters A-F and a-f share their low nibble 1..6.
			d.valid = 1'b1;
			d.value = c[3:0] + 4'd9;
		end
		return d;
	endfunction

	// Appends one byte to a result group; a full group ignores it.
	function automatic nhe_result_t put(input nhe_result_t r, input logic [7:0] b);
		nhe_result_t o;
		o = r;
		if (r.count < CntW'(MaxOut)) begin
			o.data[r.count[1:0]] = b;
			o.count = r.count + CntW'(1);
		end
		return o;
	endfunction

endpackage

// ----- rtl/nhe_step.sv -----
// ----------------------------------------------------------------------------
// nhe_step
// Combinational conversion of one input beat: produces up to four result
// bytes and the next scanner state for encode or decode mode.
// ----------------------------------------------------------------------------
module nhe_step
	import nhe_pkg::*;
(
	input  logic        dir,
	input  nhe_state_t  st,
	input  logic [7:0]  in_byte,
	input  logic        name_end,
	input  logic        no_byte,
	output nhe_state_t  st_next,
	output nhe_result_t res
);

	always_comb begin
		nhe_state_t  nx;
		nhe_result_t r;
		nhe_digit_t  lo;
		nhe_digit_t  hi;
		nx = st;
		r  = '0;
		lo = hex_digit(in_byte);
		hi = hex_digit(st.held);
		if (no_byte && !name_end) begin
			// An empty beat that does not end a name changes nothing.
		end else if (!dir) begin
			if (st.at_start) begin
				r = put(r, SlashChar);
			end
			nx.at_start = 1'b0;
			if (!no_byte) begin
				if (is_safe(in_byte)) begin
					r = put(r, in_byte);
				end else begin
					r = put(r, HashChar);
					r = put(r, HexUpper[in_byte[7:4] & NibbleMask]);
					r = put(r, HexUpper[in_byte[3:0] & NibbleMask]);
				end
			end
		end else begin
			if (!no_byte) begin
				if (st.at_start && in_byte == SlashChar) begin
					// The leading slash of a name is dropped.
				end else if (st.pend == 2'd0) begin
					if (in_byte == HashChar) begin
						nx.pend = 2'd1;
					end else begin
						r = put(r, in_byte);
					end
				end else if (st.pend == 2'd1) begin
					if (lo.valid) begin
						nx.held = in_byte;
						nx.pend = 2'd2;
					end else begin
						r = put(r, HashChar);
						if (in_byte == HashChar) begin
							nx.pend = 2'd1;
						end else begin
							nx.pend = 2'd0;
							r = put(r, in_byte);
						end
					end
				end else begin
					nx.pend = 2'd0;
					if (lo.valid && hi.valid) begin
						r = put(r, {hi.value, lo.value});
					end else begin
						r = put(r, HashChar);
						r = put(r, st.held);
						if (in_byte == HashChar) begin
							nx.pend = 2'd1;
						end else begin
							r = put(r, in_byte);
						end
					end
					nx.held = 8'h00;
				end
				nx.at_start = 1'b0;
			end
			if (name_end) begin
				// Whatever is still held goes out literally, in order.
				if (nx.pend >= 2'd1) begin
					r = put(r, HashChar);
				end
				if (nx.pend >= 2'd2) begin
					r = put(r, nx.held);
				end
				nx.pend = 2'd0;
				nx.held = 8'h00;
			end
		end
		if (name_end) begin
			nx.at_start = 1'b1;
			r.last      = 1'b1;
		end
		st_next = nx;
		res     = r;
	end

endmodule

// ----- rtl/name_hex_escape_codec.sv -----
// Flow: an accepted input beat is registered, then converted into the result buffer.
// Throughput: one input beat per cycle while each produces at most one result
// and the output is ready; a beat that expands to more results holds the input
// side while the single-byte output port drains the four-entry result buffer.
// Reset: arst_n clears direction to encode and the scanner to a name start.
// ----------------------------------------------------------------------------
// name_hex_escape_codec
// Streaming codec that escapes raw bytes into name syntax with #XX hex
// escapes, or decodes such names back to raw bytes.
// ----------------------------------------------------------------------------
module name_hex_escape_codec
	import nhe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,     // direction: 0 encode, 1 decode
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,       // [7:0] in_byte
	input  logic       s_tlast,       // name_end
	input  logic       s_tuser,       // no_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,       // [7:0] out_byte
	output logic       m_tlast        // out_last
);

	logic                   dir_q;
	nhe_state_t             state_q;
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   end_s1;
	logic                   nob_s1;
	logic [MaxOut-1:0][7:0] buf_data_q;
	logic [CntW-1:0]        buf_cnt_q;
	logic                   buf_last_q;
	nhe_state_t             st_next;
	nhe_result_t            res;
	logic                   s1_move;
	logic                   out_beat;

	nhe_step u_step (
		.dir      (dir_q),
		.st       (state_q),
		.in_byte  (byte_s1),
		.name_end (end_s1),
		.no_byte  (nob_s1),
		.st_next  (st_next),
		.res      (res)
	);

	assign out_beat = m_tvalid && m_tready;
	// The staged beat converts once the buffer is empty or sends its last byte.
	assign s1_move  = valid_s1 && (buf_cnt_q == '0 || (buf_cnt_q == CntW'(1) && m_tready));
	assign s_tready = !valid_s1 || s1_move;

	assign m_tvalid = buf_cnt_q != '0;
	assign m_tdata  = buf_data_q[0];
	assign m_tlast  = buf_last_q && buf_cnt_q == CntW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q     <= 1'b0;
			state_q   <= StateReset;
			valid_s1  <= 1'b0;
			buf_cnt_q <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (cfg_we) begin
				dir_q   <= cfg_wdata;
				state_q <= StateReset;
			end else if (s1_move) begin
				state_q <= st_next;
			end
			if (s1_move) begin
				buf_cnt_q <= res.count;
			end else if (out_beat) begin
				buf_cnt_q <= buf_cnt_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tlast;
			nob_s1  <= s_tuser;
		end
		if (s1_move) begin
			buf_data_q <= res.data;
			buf_last_q <= res.last;
		end else if (out_beat) begin
			buf_data_q <= buf_data_q >> 8;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		buf_cnt_q <= CntW'(MaxOut))
		else $error("result buffer count exceeds its depth");

	a_pend_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pend != 2'd3)
		else $error("decode pending count reached three");

	a_enc_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		!dir_q |-> state_q.pend == 2'd0)
		else $error("encode mode holds pending decode characters");

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> state_q.at_start && state_q.pend == 2'd0)
		else $error("direction write did not restart the name");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the name hex escape codec. A behavioral predictor
// tracks the scanner state and queues the expected output beats for every
// accepted input beat; a monitor compares each output beat in order. Runs a
// directed set for encode, decode and direction writes, then random names
// under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb
	import nhe_pkg::*;
();

	localparam logic DirEncode  = 1'b0;
	localparam logic DirDecode  = 1'b1;
	localparam int   NotHex     = 16;
	localparam int   CycleLimit = 200000;
	localparam int   DrainWait  = 6;

	typedef struct packed {
		logic [7:0] ch;
		logic       last_flag;
	} out_beat_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       s_tvalid  = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata   = 8'h00;
	logic       s_tlast   = 1'b0;
	logic       s_tuser   = 1'b0;
	logic       m_tvalid;
	logic       m_tready  = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;

	// Predictor copy of the codec state.
	logic       dir_mode;
	logic       at_start;
	logic [1:0] pend_cnt;
	logic [7:0] held_ch;
	int         step_n;

	out_beat_t  out_q [$];
	int         errors         = 0;
	int         items_sent     = 0;
	int         cycles         = 0;
	int         send_idle_pct  = 0;
	int         recv_stall_pct = 0;

	name_hex_escape_codec DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("FAIL name_hex_escape_codec");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic logic is_name_safe(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
		       (c >= "0" && c <= "9") || c == "_" || c == "-" || c == ".";
	endfunction

	function automatic int digit_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		return NotHex;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 4'd10) ? 8'(8'h30 + n) : 8'(8'h37 + n);
	endfunction

	function automatic void push_char(input logic [7:0] c);
		if (step_n < MaxOut) begin
			out_q.insert(out_q.size(), '{ch: c, last_flag: 1'b0});
			step_n++;
		end
	endfunction

	// A character that does not complete an escape either opens one or passes.
	function automatic void scan_plain(input logic [7:0] c);
		if (c == HashChar)
			pend_cnt = 2'd1;
		else
			push_char(c);
	endfunction

	function automatic void convert_item(input logic [7:0] c, input logic e, input logic nb);
		int        hi;
		int        lo;
		out_beat_t tail;
		step_n = 0;
		if (nb && !e) return;
		if (dir_mode == DirEncode) begin
			if (at_start) push_char(SlashChar);
			at_start = 1'b0;
			if (!nb) begin
				if (is_name_safe(c)) begin
					push_char(c);
				end else begin
					push_char(HashChar);
					push_char(hex_char(c[7:4]));
					push_char(hex_char(c[3:0]));
				end
			end
		end else begin
			if (!nb) begin
				if (!(at_start && c == SlashChar)) begin
					if (pend_cnt == 2'd0) begin
						scan_plain(c);
					end else if (pend_cnt == 2'd1) begin
						if (digit_of(c) != NotHex) begin
							held_ch  = c;
							pend_cnt = 2'd2;
						end else begin
							pend_cnt = 2'd0;
							push_char(HashChar);
							scan_plain(c);
						end
					end else begin
						lo       = digit_of(c);
						hi       = digit_of(held_ch);
						pend_cnt = 2'd0;
						if (lo != NotHex && hi != NotHex) begin
							push_char(8'((hi << 4) | lo));
						end else begin
							push_char(HashChar);
							push_char(held_ch);
							scan_plain(c);
						end
						held_ch = 8'h00;
					end
				end
				at_start = 1'b0;
			end
			if (e) begin
				if (pend_cnt >= 2'd1) push_char(HashChar);
				if (pend_cnt >= 2'd2) push_char(held_ch);
				pend_cnt = 2'd0;
				held_ch  = 8'h00;
			end
		end
		if (e) begin
			at_start = 1'b1;
			if (step_n > 0) begin
				tail           = out_q.pop_back();
				tail.last_flag = 1'b1;
				out_q.insert(out_q.size(), tail);
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Output monitor
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (out_q.size() == 0) begin
				$display("%0t: unexpected output beat, actual byte %02h last %0b",
				         $time, m_tdata, m_tlast);
				errors++;
			end else begin
				want = out_q.pop_front();
				if (m_tdata !== want.ch) begin
					$display("%0t: out_byte mismatch, expected %02h actual %02h",
					         $time, want.ch, m_tdata);
					errors++;
				end
				if (m_tlast !== want.last_flag) begin
					$display("%0t: out_last mismatch, expected %0b actual %0b",
					         $time, want.last_flag, m_tlast);
					errors++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic send_item(input logic [7:0] b, input logic e, input logic nb);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= e;
		s_tuser  <= nb;
		do @(posedge clk); while (!s_tready);
		convert_item(b, e, nb);
		items_sent++;
	endtask

	// Stop sending and let every outstanding beat drain, plus pipeline slack
	// for beats that produce no output.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (out_q.size() != 0) @(posedge clk);
		repeat (DrainWait) @(posedge clk);
	endtask

	task automatic set_direction(input logic d);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we   <= 1'b0;
		dir_mode = d;
		at_start = 1'b1;
		pend_cnt = 2'd0;
		held_ch  = 8'h00;
	endtask

	task automatic send_text(input string txt, input logic end_it);
		for (int k = 0; k < txt.len(); k++)
			send_item(txt[k], end_it && (k == txt.len() - 1), 1'b0);
	endtask

	function automatic logic [7:0] rand_hex_char();
		int v;
		v = $urandom_range(21);
		if (v < 10) return 8'("0" + v);
		if (v < 16) return 8'("A" + v - 10);
		return 8'("a" + v - 16);
	endfunction

	function automatic logic [7:0] rand_safe_char();
		int v;
		v = $urandom_range(64);
		if (v < 26) return 8'("a" + v);
		if (v < 52) return 8'("A" + v - 26);
		if (v < 62) return 8'("0" + v - 52);
		if (v == 62) return "_";
		if (v == 63) return "-";
		return ".";
	endfunction

	task automatic send_random_name(input logic d);
		logic [7:0] nm [$];
		int         len;
		int         tok;
		logic       end_by_empty;
		if ($urandom_range(9) == 0) begin
			send_item(8'($urandom_range(255)), 1'b1, 1'b1);
			return;
		end
		if (d == DirDecode) begin
			// Mostly well formed escapes, with broken and truncated ones mixed in.
			if ($urandom_range(3) != 0) nm.insert(nm.size(), SlashChar);
			len = $urandom_range(1, 4);
			for (int k = 0; k < len; k++) begin
				tok = $urandom_range(9);
				if (tok <= 3) begin
					nm.insert(nm.size(), rand_safe_char());
				end else if (tok <= 6) begin
					nm.insert(nm.size(), HashChar);
					nm.insert(nm.size(), rand_hex_char());
					nm.insert(nm.size(), rand_hex_char());
				end else if (tok == 7) begin
					nm.insert(nm.size(), HashChar);
					nm.insert(nm.size(), 8'($urandom_range(255)));
				end else if (tok == 8) begin
					nm.insert(nm.size(), HashChar);
					nm.insert(nm.size(), rand_hex_char());
					nm.insert(nm.size(), 8'($urandom_range(255)));
				end else begin
					nm.insert(nm.size(), 8'($urandom_range(255)));
				end
			end
			if ($urandom_range(4) == 0 && nm.size() > 1) void'(nm.pop_back());
		end else begin
			len = $urandom_range(1, 6);
			for (int k = 0; k < len; k++)
				nm.insert(nm.size(),
				          $urandom_range(1) ? rand_safe_char() : 8'($urandom_range(255)));
		end
		end_by_empty = ($urandom_range(7) == 0);
		for (int k = 0; k < nm.size(); k++) begin
			if ($urandom_range(11) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
			send_item(nm[k], !end_by_empty && (k == nm.size() - 1), 1'b0);
		end
		if (end_by_empty) send_item(8'($urandom_range(255)), 1'b1, 1'b1);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_encode_directed();
		set_direction(DirEncode);
		send_item(8'hA5, 1'b1, 1'b1);          // empty name gives a lone slash
		send_item(8'h5A, 1'b0, 1'b1);          // ignored beat
		send_item(8'h00, 1'b0, 1'b0);
		send_text("zA9_-.", 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h23, 1'b0, 1'b0);
		send_item(8'h2F, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);          // end without byte mid-name
	endtask

	task automatic test_decode_directed();
		set_direction(DirDecode);
		send_text("/", 1'b1);                   // decodes to nothing
		send_text("/#41#fF#4", 1'b1);           // held digit flushed at the end
		send_text("#g", 1'b1);
		send_text("#4x#", 1'b1);
		send_item(HashChar, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);           // pending hash flushed by empty end
		send_item(8'h00, 1'b1, 1'b1);           // nothing left to flush
	endtask

	task automatic test_direction_write();
		set_direction(DirDecode);
		send_item(HashChar, 1'b0, 1'b0);
		// Rewriting the direction drops the held hash and restarts the name.
		set_direction(DirDecode);
		send_text("/A", 1'b1);
	endtask

	task automatic run_traffic_phase(input logic d, input int send_pct, input int recv_pct,
	                                 input int n_items, input logic hold_off);
		int start_cnt;
		set_direction(d);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		start_cnt      = items_sent;
		while (items_sent - start_cnt < n_items) begin
			send_random_name(d);
			if (hold_off && items_sent - start_cnt >= n_items / 2) begin
				wait_idle();
				hold_off = 1'b0;
			end
		end
	endtask

	task automatic test_random_traffic();
		run_traffic_phase(DirEncode, 0, 0, 32, 1'b1);
		run_traffic_phase(DirDecode, 0, 0, 32, 1'b0);
		run_traffic_phase(DirEncode, 87, 0, 32, 1'b0);
		run_traffic_phase(DirDecode, 87, 0, 32, 1'b1);
		run_traffic_phase(DirEncode, 0, 87, 32, 1'b0);
		run_traffic_phase(DirDecode, 0, 87, 32, 1'b0);
		run_traffic_phase(DirEncode, 33, 33, 32, 1'b0);
		run_traffic_phase(DirDecode, 33, 33, 32, 1'b1);
	endtask

	initial begin
		dir_mode = DirEncode;
		at_start = 1'b1;
		pend_cnt = 2'd0;
		held_ch  = 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_encode_directed();
		test_decode_directed();
		test_direction_write();
		test_random_traffic();

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		wait_idle();
		if (errors == 0 && out_q.size() == 0) begin
			$display("PASS name_hex_escape_codec");
		end else begin
			$display("FAIL name_hex_escape_codec");
		end
		$finish;
	end

endmodule
